// File: src/mpf_pkg.sv
`default_nettype none

package mpf_pkg;

  localparam int MAX_POINTS = 64;
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam int PROP_W = $clog2(MAX_POINTS);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
  } point_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               last_point;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] mx;
    logic signed [31:0] my;
    logic               final_result;
  } out_word_t;

  typedef struct packed {
    logic               valid;
    point_t             pt;
    logic               dom;
    logic               have;
    logic signed [31:0] sm;
  } cell_state_t;

  typedef struct packed {
    logic   ins;
    logic   prop;
    logic   mark;
    logic   shift;
    point_t new_pt;
  } cell_ctl_t;

endpackage

`default_nettype wire

// File: src/mpf_cell.sv
`default_nettype none

module mpf_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire mpf_pkg::cell_ctl_t   ctl,
  input  wire mpf_pkg::cell_state_t left,
  input  wire logic                left_g,
  input  wire mpf_pkg::cell_state_t right,
  output mpf_pkg::cell_state_t      st,
  output logic                     g
);
  import mpf_pkg::*;

  logic after_new;

  // held point sorts strictly after the incoming one, or cell is empty
  assign after_new = (st.pt.x > ctl.new_pt.x) ||
                     ((st.pt.x == ctl.new_pt.x) && (st.pt.y > ctl.new_pt.y));
  assign g = !st.valid || after_new;

  always_ff @(posedge clk) begin
    if (ctl.ins && g) begin
      st.pt <= left_g ? left.pt : ctl.new_pt;
    end else if (ctl.shift) begin
      st.pt <= right.pt;
    end
    if (rst) begin
      st.have <= 1'b0;
    end else if (ctl.prop) begin
      st.have <= right.valid;
    end
    if (ctl.prop) begin
      st.sm   <= (right.have && (right.sm > right.pt.y)) ? right.sm : right.pt.y;
    end
    if (ctl.mark) begin
      st.dom <= st.have && (st.pt.y <= st.sm);
    end else if (ctl.shift) begin
      st.dom <= right.dom;
    end
    if (rst) begin
      st.valid <= 1'b0;
    end else if (ctl.ins && g) begin
      st.valid <= left_g ? left.valid : 1'b1;
    end else if (ctl.shift) begin
      st.valid <= right.valid;
    end
  end

endmodule

`default_nettype wire

// File: src/maximal_points_finder.sv
// channel | dir | payload    | handshake
// in      | in  | in_word_t  | in_valid / in_ready
// out     | out | out_word_t | out_valid / out_ready
//
// points load one per cycle into a sorted insertion chain, ready held high while loading
// after the marked point: suffix-max propagation in S_PROP, then a mark step in S_MARK
// emission shifts one cell per cycle unless stalled; dominated cells skipped without a word
// an empty head after the final word returns to loading; points past MAX_POINTS dropped
// rst is synchronous and empties the chain; out_ready low holds a waiting word at the head
`default_nettype none

module maximal_points_finder (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire mpf_pkg::in_word_t  in_word,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output mpf_pkg::out_word_t      out_word
);
  import mpf_pkg::*;

  localparam logic [1:0] S_LOAD = 2'd0;
  localparam logic [1:0] S_PROP = 2'd1;
  localparam logic [1:0] S_MARK = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic [PROP_W-1:0] prop_cnt;
  cell_ctl_t         ctl;
  cell_state_t       cell_st [MAX_POINTS];
  logic              g [MAX_POINTS];
  logic              in_acc;
  logic              room;

  assign in_ready  = (state == S_LOAD);
  assign in_acc    = in_valid && in_ready;
  assign room      = (count < CNT_W'(MAX_POINTS));
  assign out_valid = (state == S_EMIT) && cell_st[0].valid && !cell_st[0].dom;
  assign out_word.mx = cell_st[0].pt.x;
  assign out_word.my = cell_st[0].pt.y;
  assign out_word.final_result = (MAX_POINTS > 1) ? !cell_st[1].valid : 1'b1;

  always_comb begin
    ctl.ins      = in_acc && room;
    ctl.prop     = (state == S_PROP);
    ctl.mark     = (state == S_MARK);
    ctl.shift    = (state == S_EMIT) && cell_st[0].valid && (cell_st[0].dom || out_ready);
    ctl.new_pt.x = in_word.px;
    ctl.new_pt.y = in_word.py;
  end

  for (genvar i = 0; i < MAX_POINTS; i++) begin : g_chain
    cell_state_t left_st;
    cell_state_t right_st;
    logic        left_g;
    if (i == 0) begin : g_head
      assign left_st = '0;
      assign left_g  = 1'b0;
    end else begin : g_mid
      assign left_st = cell_st[i-1];
      assign left_g  = g[i-1];
    end
    if (i == MAX_POINTS - 1) begin : g_tail
      assign right_st = '0;
    end else begin : g_body
      assign right_st = cell_st[i+1];
    end
    mpf_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl),
      .left   (left_st),
      .left_g (left_g),
      .right  (right_st),
      .st     (cell_st[i]),
      .g      (g[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      count    <= '0;
      prop_cnt <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (room) begin
              count <= count + CNT_W'(1);
            end
            if (in_word.last_point) begin
              state    <= S_PROP;
              prop_cnt <= '0;
            end
          end
        end
        S_PROP: begin
          prop_cnt <= prop_cnt + PROP_W'(1);
          if (prop_cnt == PROP_W'(MAX_POINTS - 2)) begin
            state <= S_MARK;
          end
        end
        S_MARK: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!cell_st[0].valid) begin
            state <= S_LOAD;
            count <= '0;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_final_empties: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_word.final_result |=> !cell_st[0].valid)
    else $error("chain not empty after final word");

  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOAD) && (count == '0) |-> !cell_st[0].valid)
    else $error("stale cell at start of set");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_POINTS))
    else $error("point count overflow");

  a_packed: assert property (@(posedge clk) disable iff (rst)
    cell_st[1].valid |-> cell_st[0].valid)
    else $error("chain has a gap at its head");
`endif

endmodule

`default_nettype wire

// File: verif/tb_maximal_points_finder.sv
`default_nettype none

module tb_maximal_points_finder;
  timeunit 1ns;
  timeprecision 1ps;

  import mpf_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_word;

  maximal_points_finder uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state: points of the set being loaded
  point_t    set_buf [MAX_POINTS];
  int        set_len = 0;
  out_word_t expected_maxima [$];
  out_word_t expected_head;

  int  points_sent = 0;
  int  sets_sent = 0;
  int  maxima_checked = 0;
  int  mismatches = 0;
  int  stall_cycles = 0;
  int  rx_hold_len = 0;
  bit  tx_idle_on = 1'b1;
  bit  rx_idle_on = 1'b1;

  function automatic bit comes_after(point_t a, point_t b);
    if ($signed(a.x) > $signed(b.x)) return 1'b1;
    if (a.x == b.x && $signed(a.y) > $signed(b.y)) return 1'b1;
    return 1'b0;
  endfunction

  task automatic compute_maxima();
    point_t key;
    int j;
    logic signed [31:0] best_y;
    bit keep [MAX_POINTS];
    int survivors;
    int emitted;
    out_word_t w;
    for (int i = 1; i < set_len; i++) begin
      key = set_buf[i];
      j = i;
      while (j > 0 && comes_after(set_buf[j-1], key)) begin
        set_buf[j] = set_buf[j-1];
        j--;
      end
      set_buf[j] = key;
    end
    keep[set_len-1] = 1'b1;
    best_y = set_buf[set_len-1].y;
    survivors = 1;
    for (int k = set_len - 2; k >= 0; k--) begin
      if ($signed(set_buf[k].y) > best_y) begin
        keep[k] = 1'b1;
        best_y = set_buf[k].y;
        survivors++;
      end else begin
        keep[k] = 1'b0;
      end
    end
    emitted = 0;
    for (int i = 0; i < set_len; i++) begin
      if (keep[i]) begin
        emitted++;
        w.mx = set_buf[i].x;
        w.my = set_buf[i].y;
        w.final_result = (emitted == survivors);
        expected_maxima.push_back(w);
      end
    end
    set_len = 0;
  endtask

  task automatic absorb_point(in_word_t w);
    points_sent++;
    if (set_len < MAX_POINTS) begin
      set_buf[set_len].x = w.px;
      set_buf[set_len].y = w.py;
      set_len++;
    end
    if (w.last_point) begin
      sets_sent++;
      compute_maxima();
    end
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic last);
    int gaps;
    in_word_t w;
    gaps = 0;
    while (tx_idle_on && gaps < 6 && $urandom_range(99) < 26) gaps++;
    if (gaps > 0) begin
      in_valid <= 1'b0;
      repeat (gaps) @(posedge clk);
    end
    w.px = x;
    w.py = y;
    w.last_point = last;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (!in_ready);
    absorb_point(w);
  endtask

  task automatic wait_for_maxima();
    if (expected_maxima.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_maxima.size() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord(int mode);
    logic [31:0] v;
    case (mode)
      0: v = $urandom_range(8) - 4;
      1: v = $urandom();
      default: begin
        case ($urandom_range(5))
          0: v = 32'h8000_0000;
          1: v = 32'h7fff_ffff;
          2: v = 32'h0000_0000;
          3: v = 32'hffff_ffff;
          4: v = 32'h8000_0001;
          default: v = 32'h7fff_fffe;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic send_random_set(int size, int mode);
    logic [31:0] x;
    logic [31:0] y;
    for (int i = 0; i < size; i++) begin
      x = pick_coord(mode == 3 ? 1 : mode);
      // anti-correlated coordinates keep most points on the skyline
      y = (mode == 3) ? (-x + $urandom_range(2)) : pick_coord(mode);
      send_point(x, y, i == size - 1);
    end
  endtask

  task automatic check_lone_points();
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b1);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    send_point(32'hffff_ffff, 32'h0000_0000, 1'b1);
    wait_for_maxima();
  endtask

  task automatic check_extreme_corners();
    send_point(32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h8000_0000, 1'b1);
    // staircase, every point survives
    send_point(32'h7fff_ffff, 32'h8000_0000, 1'b0);
    send_point(32'h8000_0000, 32'h7fff_ffff, 1'b0);
    send_point(32'h0000_0000, 32'h0000_0000, 1'b1);
    wait_for_maxima();
  endtask

  task automatic check_duplicate_points();
    repeat (3) send_point(32'd5, 32'd5, 1'b0);
    send_point(32'd5, 32'd5, 1'b1);
    send_point(32'd3, 32'd1, 1'b0);
    send_point(32'd3, 32'd7, 1'b0);
    send_point(32'd3, 32'd4, 1'b0);
    send_point(32'd2, 32'd7, 1'b0);
    send_point(32'hffff_fffd, 32'd9, 1'b1);
    wait_for_maxima();
  endtask

  task automatic check_full_and_overflow();
    send_random_set(MAX_POINTS, 0);
    wait_for_maxima();
    send_random_set(MAX_POINTS + 1, 1);
    wait_for_maxima();
    send_random_set(MAX_POINTS + 6, 3);
    wait_for_maxima();
  endtask

  task automatic check_random_sets(int budget);
    int sent;
    int size;
    sent = 0;
    while (sent < budget) begin
      size = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      send_random_set(size, $urandom_range(3));
      sent += size;
      if ($urandom_range(3) == 0) wait_for_maxima();
    end
    wait_for_maxima();
  endtask

  task automatic check_no_idle();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    check_random_sets(40);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  task automatic check_output_backpressure();
    tx_idle_on = 1'b0;
    rx_hold_len = HOLD_CYCLES;
    send_random_set(5, 3);
    send_random_set(4, 0);
    send_random_set(6, 1);
    wait_for_maxima();
    tx_idle_on = 1'b1;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold_len) @(posedge clk);
        rx_hold_len = 0;
      end else if (rx_idle_on && $urandom_range(99) < 26) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_maxima.size() == 0) begin
        report_mismatch($sformatf("unexpected word x=%0d y=%0d final=%0b",
          $signed(out_word.mx), $signed(out_word.my), out_word.final_result));
      end else begin
        expected_head = expected_maxima.pop_front();
        maxima_checked++;
        if (out_word.mx !== expected_head.mx)
          report_mismatch($sformatf("mx %0d, expected %0d",
            $signed(out_word.mx), $signed(expected_head.mx)));
        if (out_word.my !== expected_head.my)
          report_mismatch($sformatf("my %0d, expected %0d",
            $signed(out_word.my), $signed(expected_head.my)));
        if (out_word.final_result !== expected_head.final_result)
          report_mismatch($sformatf("final_result %0b, expected %0b",
            out_word.final_result, expected_head.final_result));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
      $display("** maximal_points_finder: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    check_lone_points();
    check_extreme_corners();
    check_duplicate_points();
    check_random_sets(50);
    check_full_and_overflow();
    check_no_idle();
    check_output_backpressure();
    check_random_sets(20);
    wait_for_maxima();
    repeat (2 * MAX_POINTS + 16) @(posedge clk);
    $display("sent %0d points in %0d sets, checked %0d maximal points",
      points_sent, sets_sent, maxima_checked);
    $display("extremes, duplicates, full and overflowing sets, long output stall covered");
    if (mismatches == 0 && expected_maxima.size() == 0) begin
      $display("** maximal_points_finder: PASSED **");
    end else begin
      $display("** maximal_points_finder: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
